### hdl/sods_pkg.sv
// ----------------------------------------------------------------------------
// sods_pkg
// Shared types, constants and helpers of the silhouette outline styler.
// ----------------------------------------------------------------------------
package sods_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int PIX_CAP    = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(PIX_CAP);           // pixel address bits
    localparam int CW         = AW + 1;                    // pixel count bits
    localparam int XW         = $clog2(MAX_WIDTH);         // column index bits
    localparam int YW         = $clog2(MAX_HEIGHT);        // row index bits
    localparam int DIMW       = 9;                         // dimension register bits
    localparam int DSTW       = 9;                         // distance bits

    localparam int PADDR_W    = 4;
    localparam logic [1:0] REG_WIDTH   = 2'd0;
    localparam logic [1:0] REG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_FILL    = 2'd2;
    localparam logic [1:0] REG_OUTLINE = 2'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic [7:0]      cov;
        logic [DSTW-1:0] hops;
        logic [31:0]     depth;
        logic [31:0]     order;
        logic [7:0]      alpha;
    } t_pix;

    // (fill*cov + 127) / 255 through a reciprocal fold
    function automatic logic [7:0] scale_fill(input logic [7:0] fill, input logic [7:0] cov);
        logic [15:0] prod;
        logic [16:0] x;
        logic [16:0] q;
        prod = fill * cov;
        x    = {1'b0, prod} + 17'd127;
        q    = x + (x >> 8) + 17'd1;
        return q[15:8];
    endfunction

endpackage

### hdl/sods_in_if.sv
// ----------------------------------------------------------------------------
// sods_in_if
// Input channel: opcode and pixel word.
// ----------------------------------------------------------------------------
interface sods_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [7:0]         coverage;
    logic [31:0]        depth_bits;
    logic signed [31:0] pix_order;

    modport source (output valid, opcode, coverage, depth_bits, pix_order, input ready);
    modport sink   (input valid, opcode, coverage, depth_bits, pix_order, output ready);
endinterface

### hdl/sods_out_if.sv
// ----------------------------------------------------------------------------
// sods_out_if
// Output channel: styled pixel word.
// ----------------------------------------------------------------------------
interface sods_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         alpha;
    logic [31:0]        depth_out;
    logic signed [31:0] order_out;
    logic               last_pixel;

    modport source (output valid, alpha, depth_out, order_out, last_pixel, input ready);
    modport sink   (input valid, alpha, depth_out, order_out, last_pixel, output ready);
endinterface

### hdl/sods_ram.sv
// ----------------------------------------------------------------------------
// sods_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sods_ram #(
    parameter int DW = 8,
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [0:(1<<AW)-1];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/silhouette_outline_distance_style_unit.sv
// ----------------------------------------------------------------------------
// silhouette_outline_distance_style_unit
// Loads a coverage image, styles it with a two-pass city-block distance
// transform, and reads styled pixels back out.
// ----------------------------------------------------------------------------
// A load word is written as it is accepted; a fetch passes S_RD_ISSUE (waits
// for a free output register) and S_RD_DATA to a registered result. The first
// fetch after a full load styles the image, N = width*height: an init pass and,
// if the outline is non-zero, two sweeps (3 reads through the single read port
// and 1 write per pixel) and a final pass; input waits during fetch or styling.
// Reset clears control state only; pixel memory contents are undefined.
module silhouette_outline_distance_style_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sods_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    sods_in_if.sink                     i_in,
    sods_out_if.source                  o_out
);
    localparam int AW = sods_pkg::AW;
    localparam int CW = sods_pkg::CW;
    localparam int XW = sods_pkg::XW;
    localparam int YW = sods_pkg::YW;
    localparam int DIMW = sods_pkg::DIMW;
    localparam int DSTW = sods_pkg::DSTW;

    // phases of the image
    localparam logic [1:0] PH_LOADING = 2'd0;
    localparam logic [1:0] PH_LOADED  = 2'd1;
    localparam logic [1:0] PH_READING = 2'd2;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INIT_RD  = 4'd1;
    localparam logic [3:0] S_INIT_WR  = 4'd2;
    localparam logic [3:0] S_SW_DST   = 4'd3;
    localparam logic [3:0] S_SW_N1    = 4'd4;
    localparam logic [3:0] S_SW_N2    = 4'd5;
    localparam logic [3:0] S_SW_WR    = 4'd6;
    localparam logic [3:0] S_FIN_RD   = 4'd7;
    localparam logic [3:0] S_FIN_WR   = 4'd8;
    localparam logic [3:0] S_RD_ISSUE = 4'd9;
    localparam logic [3:0] S_RD_DATA  = 4'd10;

    // configuration registers
    logic [DIMW-1:0] r_img_w, r_img_h;
    logic [7:0]      r_fill, r_outline;

    logic            cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w   <= DIMW'(sods_pkg::MAX_WIDTH);
            r_img_h   <= DIMW'(sods_pkg::MAX_HEIGHT);
            r_fill    <= 8'd255;
            r_outline <= 8'd0;
        end else if (cfg_wr && paddr[1:0] == 2'b00) begin
            case (paddr[3:2])
                sods_pkg::REG_WIDTH:   r_img_w   <= pwdata[DIMW-1:0];
                sods_pkg::REG_HEIGHT:  r_img_h   <= pwdata[DIMW-1:0];
                sods_pkg::REG_FILL:    r_fill    <= pwdata[7:0];
                sods_pkg::REG_OUTLINE: r_outline <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sods_pkg::REG_WIDTH:   prdata = {{(32-DIMW){1'b0}}, r_img_w};
            sods_pkg::REG_HEIGHT:  prdata = {{(32-DIMW){1'b0}}, r_img_h};
            sods_pkg::REG_FILL:    prdata = {24'd0, r_fill};
            sods_pkg::REG_OUTLINE: prdata = {24'd0, r_outline};
            default:               prdata = 32'd0;
        endcase
    end

    // effective dimensions: clamp zero to one and large values to the maximum
    logic [DIMW-1:0] ew, eh;
    logic [CW-1:0]   n_pix;
    logic [2*DIMW-1:0] area;

    always_comb begin
        if (r_img_w == '0) ew = DIMW'(1);
        else if (r_img_w > DIMW'(sods_pkg::MAX_WIDTH)) ew = DIMW'(sods_pkg::MAX_WIDTH);
        else ew = r_img_w;
        if (r_img_h == '0) eh = DIMW'(1);
        else if (r_img_h > DIMW'(sods_pkg::MAX_HEIGHT)) eh = DIMW'(sods_pkg::MAX_HEIGHT);
        else eh = r_img_h;
        area  = ew * eh;
        n_pix = area[CW-1:0];
    end

    // pixel memory
    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    sods_pkg::t_pix          ram_wdata, ram_rdata;

    sods_ram #(.DW($bits(sods_pkg::t_pix)), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // relax dst against src: strict-less update copies the source subject
    function automatic sods_pkg::t_pix relax(input sods_pkg::t_pix dst,
                                             input sods_pkg::t_pix src,
                                             input logic en);
        sods_pkg::t_pix res;
        logic [DSTW:0]  cand;
        res  = dst;
        cand = {1'b0, src.hops} + (DSTW+1)'(1);
        if (en && cand < {1'b0, dst.hops}) begin
            res.hops  = cand[DSTW-1:0];
            res.depth = src.depth;
            res.order = src.order;
            res.alpha = src.alpha;
        end
        return res;
    endfunction

    logic [3:0]     r_state, n_state;
    logic [1:0]     r_phase, n_phase;
    logic [CW-1:0]  r_lc, n_lc, r_rc, n_rc;
    logic [AW-1:0]  r_addr, n_addr;
    logic [XW-1:0]  r_x, n_x;
    logic [YW-1:0]  r_y, n_y;
    logic           r_fwd, n_fwd;
    sods_pkg::t_pix r_cur, n_cur;

    logic           r_ovalid, n_ovalid;
    logic [7:0]     r_oalpha, n_oalpha;
    logic [31:0]    r_odepth, n_odepth;
    logic [31:0]    r_oorder, n_oorder;
    logic           r_olast, n_olast;

    logic           in_acc, out_free;
    logic [CW-1:0]  load_idx, load_next;
    logic           has_n1, has_n2, last_x, first_x;
    logic [AW-1:0]  n1_addr, n2_addr;
    sods_pkg::t_pix pix_mod;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_ovalid || o_out.ready;

    assign first_x = (r_x == '0);
    assign last_x  = ({1'b0, r_x} == ew - DIMW'(1));
    assign has_n1  = r_fwd ? !first_x : !last_x;
    assign has_n2  = r_fwd ? (r_y != '0) : ({1'b0, r_y} + DIMW'(1) < eh);
    assign n1_addr = r_fwd ? r_addr - AW'(1) : r_addr + AW'(1);
    assign n2_addr = r_fwd ? r_addr - AW'(ew) : r_addr + AW'(ew);

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_lc     = r_lc;
        n_rc     = r_rc;
        n_addr   = r_addr;
        n_x      = r_x;
        n_y      = r_y;
        n_fwd    = r_fwd;
        n_cur    = r_cur;
        n_ovalid = r_ovalid && !o_out.ready;
        n_oalpha = r_oalpha;
        n_odepth = r_odepth;
        n_oorder = r_oorder;
        n_olast  = r_olast;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_addr;
        pix_mod   = ram_rdata;

        load_idx  = (r_phase != PH_LOADING || r_lc >= n_pix) ? '0 : r_lc;
        load_next = load_idx + CW'(1);

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.opcode == sods_pkg::OP_LOAD) begin
                        // store the word; a load after a finished image restarts
                        ram_we          = 1'b1;
                        ram_waddr       = load_idx[AW-1:0];
                        ram_wdata.cov   = i_in.coverage;
                        ram_wdata.hops  = '0;
                        ram_wdata.depth = i_in.depth_bits;
                        ram_wdata.order = i_in.pix_order;
                        ram_wdata.alpha = '0;
                        n_lc    = load_next;
                        n_rc    = '0;
                        n_phase = (load_next == n_pix) ? PH_LOADED : PH_LOADING;
                    end else if (r_phase == PH_LOADED) begin
                        n_addr  = '0;
                        n_state = S_INIT_RD;
                    end else if (r_phase == PH_READING) begin
                        n_state = S_RD_ISSUE;
                    end
                end
            end
            S_INIT_RD: begin
                ram_re  = 1'b1;
                n_state = S_INIT_WR;
            end
            S_INIT_WR: begin
                // seed distance and alpha, or scale directly when fill only
                if (r_outline == '0) begin
                    pix_mod.alpha = sods_pkg::scale_fill(r_fill, ram_rdata.cov);
                end else begin
                    pix_mod.hops  = (ram_rdata.cov != '0) ? '0
                                  : DSTW'({1'b0, r_outline} + 9'd1);
                    pix_mod.alpha = ram_rdata.cov;
                end
                ram_we    = 1'b1;
                ram_wdata = pix_mod;
                if ({1'b0, r_addr} == n_pix - CW'(1)) begin
                    if (r_outline == '0) begin
                        n_phase = PH_READING;
                        n_rc    = '0;
                        n_state = S_RD_ISSUE;
                    end else begin
                        n_addr  = '0;
                        n_x     = '0;
                        n_y     = '0;
                        n_fwd   = 1'b1;
                        n_state = S_SW_DST;
                    end
                end else begin
                    n_addr  = r_addr + AW'(1);
                    n_state = S_INIT_RD;
                end
            end
            S_SW_DST: begin
                ram_re  = 1'b1;
                n_state = S_SW_N1;
            end
            S_SW_N1: begin
                n_cur     = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = n1_addr;
                n_state   = S_SW_N2;
            end
            S_SW_N2: begin
                n_cur     = relax(r_cur, ram_rdata, has_n1);
                ram_re    = 1'b1;
                ram_raddr = n2_addr;
                n_state   = S_SW_WR;
            end
            S_SW_WR: begin
                ram_we    = 1'b1;
                ram_wdata = relax(r_cur, ram_rdata, has_n2);
                n_state   = S_SW_DST;
                if (r_fwd) begin
                    if ({1'b0, r_addr} == n_pix - CW'(1)) begin
                        // turn around for the backward sweep
                        n_fwd = 1'b0;
                        n_x   = XW'(ew - DIMW'(1));
                        n_y   = YW'(eh - DIMW'(1));
                    end else begin
                        n_addr = r_addr + AW'(1);
                        if (last_x) begin
                            n_x = '0;
                            n_y = r_y + YW'(1);
                        end else begin
                            n_x = r_x + XW'(1);
                        end
                    end
                end else begin
                    if (r_addr == '0) begin
                        n_state = S_FIN_RD;
                    end else begin
                        n_addr = r_addr - AW'(1);
                        if (first_x) begin
                            n_x = XW'(ew - DIMW'(1));
                            n_y = r_y - YW'(1);
                        end else begin
                            n_x = r_x - XW'(1);
                        end
                    end
                end
            end
            S_FIN_RD: begin
                ram_re  = 1'b1;
                n_state = S_FIN_WR;
            end
            S_FIN_WR: begin
                if (ram_rdata.cov != '0) begin
                    pix_mod.alpha = sods_pkg::scale_fill(r_fill, ram_rdata.cov);
                end else if (ram_rdata.hops > DSTW'(r_outline)) begin
                    pix_mod.alpha = '0;
                end
                ram_we    = 1'b1;
                ram_wdata = pix_mod;
                if ({1'b0, r_addr} == n_pix - CW'(1)) begin
                    n_phase = PH_READING;
                    n_rc    = '0;
                    n_state = S_RD_ISSUE;
                end else begin
                    n_addr  = r_addr + AW'(1);
                    n_state = S_FIN_RD;
                end
            end
            S_RD_ISSUE: begin
                if (r_rc >= n_pix) begin
                    // image shrank under the reader: drop the fetch
                    n_phase = PH_LOADING;
                    n_lc    = '0;
                    n_rc    = '0;
                    n_state = S_IDLE;
                end else if (out_free) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_rc[AW-1:0];
                    n_state   = S_RD_DATA;
                end
            end
            S_RD_DATA: begin
                n_ovalid = 1'b1;
                n_oalpha = ram_rdata.alpha;
                n_odepth = ram_rdata.depth;
                n_oorder = ram_rdata.order;
                n_olast  = (r_rc + CW'(1) == n_pix);
                n_state  = S_IDLE;
                if (r_rc + CW'(1) == n_pix) begin
                    n_phase = PH_LOADING;
                    n_lc    = '0;
                    n_rc    = '0;
                end else begin
                    n_rc = r_rc + CW'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_LOADING;
            r_lc     <= '0;
            r_rc     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_lc     <= n_lc;
            r_rc     <= n_rc;
            r_ovalid <= n_ovalid;
        end
    end

    // walker and output payload hold no reset
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_x      <= n_x;
        r_y      <= n_y;
        r_fwd    <= n_fwd;
        r_cur    <= n_cur;
        r_oalpha <= n_oalpha;
        r_odepth <= n_odepth;
        r_oorder <= n_oorder;
        r_olast  <= n_olast;
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.alpha      = r_oalpha;
    assign o_out.depth_out  = r_odepth;
    assign o_out.order_out  = r_oorder;
    assign o_out.last_pixel = r_olast;
endmodule

### hdl/sods_chk.sv
// ----------------------------------------------------------------------------
// sods_chk
// Port-level checks of the outline styler, bound to the top level.
// ----------------------------------------------------------------------------
module sods_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_opcode,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_pready
);
    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // drop all results across reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a load word never causes a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_opcode == sods_pkg::OP_LOAD && !i_out_valid
        |=> !i_out_valid)
        else $error("result after a load");

    // a new result appears only out of a busy cycle
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("unexpected result timing");

    a_pready: assert property (@(posedge i_clk) i_pready)
        else $error("pready low");
endmodule

bind silhouette_outline_distance_style_unit sods_chk u_sods_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_opcode (i_in.opcode),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pready    (pready)
);

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the silhouette outline styler: loads coverage
// images, fetches styled pixels and compares each word with a local predictor.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 5;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_TARGET = 1550;

    typedef enum int {PH_LOADING, PH_LOADED, PH_READING} t_image_phase;

    typedef struct {
        bit [7:0]  alpha;
        bit [31:0] depth;
        bit [31:0] order;
        bit        last;
    } t_styled_pixel;

    // Predicts styled pixels and holds the ones still owed by the block.
    class style_scoreboard;
        int unsigned   width_reg, height_reg, fill_reg, outline_reg;
        bit [7:0]      cov_mem[sods_pkg::PIX_CAP];
        int unsigned   dist_mem[sods_pkg::PIX_CAP];
        bit [31:0]     depth_mem[sods_pkg::PIX_CAP];
        bit [31:0]     order_mem[sods_pkg::PIX_CAP];
        bit [7:0]      alpha_mem[sods_pkg::PIX_CAP];
        int unsigned   loads, reads;
        t_image_phase  phase;
        t_styled_pixel owed[$];
        int errors;

        function new();
            width_reg = 256; height_reg = 256; fill_reg = 255; outline_reg = 0;
            loads = 0; reads = 0; phase = PH_LOADING; errors = 0;
        endfunction

        function int unsigned eff_width();
            return (width_reg == 0) ? 1
                 : (width_reg > sods_pkg::MAX_WIDTH ? sods_pkg::MAX_WIDTH : width_reg);
        endfunction

        function int unsigned pixel_count();
            int unsigned h;
            h = (height_reg == 0) ? 1
              : (height_reg > sods_pkg::MAX_HEIGHT ? sods_pkg::MAX_HEIGHT : height_reg);
            return eff_width() * h;
        endfunction

        function void write_reg(logic [1:0] idx, int unsigned value);
            case (idx)
                sods_pkg::REG_WIDTH:   width_reg   = value & 9'h1FF;
                sods_pkg::REG_HEIGHT:  height_reg  = value & 9'h1FF;
                sods_pkg::REG_FILL:    fill_reg    = value & 8'hFF;
                sods_pkg::REG_OUTLINE: outline_reg = value & 8'hFF;
                default: ;
            endcase
        endfunction

        function bit [7:0] fill_scale(bit [7:0] cov);
            return 8'((fill_reg * cov + 127) / 255);
        endfunction

        function void pull(int unsigned dst, int unsigned src);
            if (dist_mem[src] + 1 < dist_mem[dst]) begin
                dist_mem[dst]  = dist_mem[src] + 1;
                depth_mem[dst] = depth_mem[src];
                order_mem[dst] = order_mem[src];
                alpha_mem[dst] = alpha_mem[src];
            end
        endfunction

        function void style_image();
            int unsigned w, h, n, i;
            n = pixel_count();
            w = eff_width();
            h = n / w;
            if (outline_reg == 0) begin
                for (i = 0; i < n; i++) alpha_mem[i] = fill_scale(cov_mem[i]);
                return;
            end
            for (i = 0; i < n; i++) begin
                dist_mem[i]  = (cov_mem[i] != 0) ? 0 : outline_reg + 1;
                alpha_mem[i] = cov_mem[i];
            end
            // forward sweep: left, then up
            for (int y = 0; y < h; y++)
                for (int x = 0; x < w; x++) begin
                    if (x > 0) pull(y * w + x, y * w + x - 1);
                    if (y > 0) pull(y * w + x, (y - 1) * w + x);
                end
            // backward sweep: right, then down
            for (int y = h - 1; y >= 0; y--)
                for (int x = w - 1; x >= 0; x--) begin
                    if (x + 1 < w) pull(y * w + x, y * w + x + 1);
                    if (y + 1 < h) pull(y * w + x, (y + 1) * w + x);
                end
            for (i = 0; i < n; i++) begin
                if (cov_mem[i] != 0) alpha_mem[i] = fill_scale(cov_mem[i]);
                else if (dist_mem[i] > outline_reg) alpha_mem[i] = 0;
            end
        endfunction

        function void note_word(bit op, bit [7:0] cov, bit [31:0] depth, bit [31:0] order);
            int unsigned n;
            t_styled_pixel px;
            n = pixel_count();
            if (op == sods_pkg::OP_LOAD) begin
                if (phase != PH_LOADING) begin
                    phase = PH_LOADING; loads = 0; reads = 0;
                end
                if (loads >= n) loads = 0;
                cov_mem[loads] = cov; depth_mem[loads] = depth; order_mem[loads] = order;
                loads++;
                if (loads == n) phase = PH_LOADED;
                return;
            end
            if (phase == PH_LOADING) return;
            if (phase == PH_LOADED) begin
                style_image();
                phase = PH_READING;
                reads = 0;
            end
            if (reads >= n) begin
                phase = PH_LOADING; loads = 0; reads = 0;
                return;
            end
            px.alpha = alpha_mem[reads];
            px.depth = depth_mem[reads];
            px.order = order_mem[reads];
            px.last  = (reads + 1 == n);
            owed.push_back(px);
            reads++;
            if (reads == n) begin
                phase = PH_LOADING; loads = 0; reads = 0;
            end
        endfunction

        function void check_word(bit [7:0] alpha, bit [31:0] depth, bit [31:0] order, bit last);
            t_styled_pixel px;
            if (owed.size() == 0) begin
                $error("unexpected styled pixel: alpha %0d depth %h order %h", alpha, depth, order);
                errors++;
                return;
            end
            px = owed.pop_front();
            if (alpha != px.alpha) begin
                $error("alpha: expected %0d, got %0d", px.alpha, alpha); errors++;
            end
            if (depth != px.depth) begin
                $error("depth_out: expected %h, got %h", px.depth, depth); errors++;
            end
            if (order != px.order) begin
                $error("order_out: expected %h, got %h", px.order, order); errors++;
            end
            if (last != px.last) begin
                $error("last_pixel: expected %0d, got %0d", px.last, last); errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [sods_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    sods_in_if  in_ch();
    sods_out_if out_ch();

    silhouette_outline_distance_style_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    style_scoreboard sb = new();
    int  items_sent = 0;
    int  quiet_cycles = 0;
    bit  steady = 1'b0;      // no idling on either side while set
    bit  hold_req = 1'b0;    // ask the receiver for its one long hold-off
    bit  hold_done = 1'b0;

    always #HALF_PERIOD i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.opcode = sods_pkg::OP_LOAD;
        in_ch.coverage = '0;
        in_ch.depth_bits = '0;
        in_ch.pix_order = '0;
        out_ch.ready = 1'b0;
    end

    // Receiver: random back-pressure, plus one long hold while words pile up.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            out_ch.ready = steady || ($urandom_range(99) >= 26);
        end
    end

    // Check every styled word at the edge that accepts it.
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready)
            sb.check_word(out_ch.alpha, out_ch.depth_out, out_ch.order_out, out_ch.last_pixel);
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one word; return once the block has taken it.
    task automatic send_word(bit op, bit [7:0] cov, bit [31:0] depth, bit [31:0] order);
        if (!steady && $urandom_range(99) < 26) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat ($urandom_range(2)) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.opcode = op;
        in_ch.coverage = cov;
        in_ch.depth_bits = depth;
        in_ch.pix_order = order;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_word(op, cov, depth, order);
        items_sent++;
    endtask

    task automatic send_load(bit [7:0] cov, bit [31:0] depth, bit [31:0] order);
        send_word(sods_pkg::OP_LOAD, cov, depth, order);
    endtask

    task automatic send_fetch();
        send_word(sods_pkg::OP_FETCH, $urandom_range(255), $urandom, $urandom);
    endtask

    // Drop valid and hold until every owed word is back and the block is quiet.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, int unsigned value);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = sods_pkg::PADDR_W'({idx, 2'b00});
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic configure(int unsigned w, int unsigned h, int unsigned fill,
                             int unsigned outline);
        drain();
        reg_write(sods_pkg::REG_WIDTH, w);
        reg_write(sods_pkg::REG_HEIGHT, h);
        reg_write(sods_pkg::REG_FILL, fill);
        reg_write(sods_pkg::REG_OUTLINE, outline);
    endtask

    function automatic bit [7:0] pick_coverage();
        if ($urandom_range(99) < 55) return 8'd0;
        return ($urandom_range(9) == 0) ? 8'd255 : 8'($urandom_range(1, 255));
    endfunction

    // Load one full image, then fetch part or all of it back.
    task automatic image_pass(int unsigned fetches);
        int unsigned n;
        n = sb.pixel_count();
        for (int unsigned i = 0; i < n; i++) begin
            // a stray fetch mid-load must be ignored
            if (i > 0 && $urandom_range(99) < 5) send_fetch();
            send_load(pick_coverage(), $urandom, $urandom);
        end
        for (int unsigned i = 0; i < fetches; i++) send_fetch();
    endtask

    initial begin
        int unsigned w, h, fill, outline, n, fetches, sel;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill only, field extremes; a fetch while loading yields nothing.
        configure(3, 2, 255, 0);
        send_fetch();
        send_load(8'd0,   32'h0000_0000, 32'h0000_0000);
        send_load(8'd255, 32'hFFFF_FFFF, 32'h8000_0000);
        send_load(8'd1,   32'h1234_5678, 32'h7FFF_FFFF);
        send_load(8'd128, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
        send_load(8'd0,   32'h0F0F_0F0F, 32'h0000_0001);
        send_load(8'd254, 32'hF0F0_F0F0, 32'h5555_5555);
        repeat (6) send_fetch();

        // Widest outline; shrink under an open readout so the next fetch ends it.
        configure(2, 2, 200, 255);
        send_load(8'd0,   32'hAAAA_AAAA, 32'h0000_0010);
        send_load(8'd0,   32'h5555_5555, 32'h0000_0020);
        send_load(8'd0,   32'h0000_0001, 32'h0000_0030);
        send_load(8'd200, 32'hCAFE_F00D, 32'h8000_0001);
        repeat (2) send_fetch();
        configure(1, 1, 0, 1);
        send_fetch();

        // Load into a full image restarts it.
        send_load(8'd77, 32'h1111_1111, 32'h2222_2222);
        send_load(8'd0,  32'h3333_3333, 32'h4444_4444);
        send_fetch();

        // Shrink mid-load: the load count past the new size restarts at zero.
        configure(2, 2, 128, 2);
        repeat (3) send_load(8'd9, $urandom, $urandom);
        configure(1, 2, 128, 2);
        send_load(8'd0, 32'h0BAD_F00D, 32'hFFFF_FFFE);
        send_load(8'd50, 32'h600D_CAFE, 32'h0000_0002);
        repeat (2) send_fetch();

        // Random images: mostly small, now and then the extreme shapes.
        while (items_sent < ITEM_TARGET) begin
            sel = $urandom_range(19);
            case (sel)
                0: begin w = 256; h = 1; end
                1: begin w = 1; h = 256; end
                2: begin w = 511; h = 1; end
                3: begin w = 0; h = $urandom_range(511, 260); end
                4: begin w = 0; h = 0; end
                default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 8); end
            endcase
            if (h > 256 && w != 1 && w != 0) h = 1;
            if (w == 0 && h > 256) h = 1 + (h & 1);  // keep the odd tall case small
            sel = $urandom_range(9);
            fill = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(255);
            sel = $urandom_range(9);
            outline = (sel < 3) ? 0 : (sel == 3) ? 255 : (sel == 4) ? $urandom_range(255)
                    : $urandom_range(1, 4);
            configure(w, h, fill, outline);

            steady = (items_sent > 600 && items_sent < 800);
            if (!hold_done && items_sent > 300) hold_req = 1'b1;

            n = sb.pixel_count();
            // most images read back whole; some are cut short by the next load
            fetches = ($urandom_range(99) < 12) ? $urandom_range(n) : n;
            image_pass(fetches);
        end
        steady = 1'b0;

        drain();
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
